// ----- rtl/core/memory_map_bump_allocator_defines.svh -----
`ifndef MEMORY_MAP_BUMP_ALLOCATOR_DEFINES_SVH
`define MEMORY_MAP_BUMP_ALLOCATOR_DEFINES_SVH

// same-cycle check, sampled on clk and disabled while rst_n is low
`define MMBA_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, sampled on clk and disabled while rst_n is low
`define MMBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mmba_pkg.sv -----
`timescale 1ns / 1ps

package mmba_pkg;

    // result codes carried on the status port
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_LIMIT    = 2'd2,
        STAT_STORED   = 2'd3
    } result_code_t;

    // page size and the 32-bit address ceiling
    localparam int          PAGE_BITS  = 12;
    localparam int          PAGE_BYTES = 1 << PAGE_BITS;
    localparam logic [63:0] ADDR_LIMIT = 64'h0000_0001_0000_0000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic         ld_item;
        logic         wr_region;
        logic         set_res;
        result_code_t res_code;
        logic         res_use_sum;
        logic         entry_dec;
        logic         entry_inc;
        logic         take_base;
        logic         take_end;
        logic         calc_align;
        logic         emit;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_alloc;
        logic no_regions;
        logic start_below_base;
        logic entry_zero;
        logic beyond_limit;
        logic fits;
        logic last_entry;
        logic out_free;
    } dp_flags_t;

endpackage

// ----- rtl/core/memory_map_bump_allocator.sv -----
`timescale 1ns / 1ps

// Bump allocator over a table of up to MAX_REGIONS memory regions, each a base
// and an exclusive end. A word with op 0 stores one region (status 3); a word
// with op 1 searches back for the last region whose base is at or below
// start_address, then walks forward, page-aligning the start and returning
// aligned start plus size with status 0, or 0 with status 1 (no space) or
// 2 (start plus size beyond 4 GiB). region_count is written on the cfg port;
// the user must write it only while the block is idle; the block itself does not
// enforce this. One word is processed at a time: a region store is written in
// the idle state and handed over from the done state; an allocation steps back
// through a wait and a check state per region, then for each region visited
// forward runs a limit check, which can end it, and a fit check, with a wait
// and a load state between regions. The region table has one registered read
// port. A finished word waits in an output register while the next is taken.
module memory_map_bump_allocator #(
    parameter int MAX_REGIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [3:0]  region_index,
    input  logic [63:0] region_base,
    input  logic [63:0] region_end,
    input  logic [63:0] start_address,
    input  logic [31:0] alloc_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] end_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  region_count
);

    mmba_pkg::dp_cmd_t   cmd;
    mmba_pkg::dp_flags_t flags;

    // the count register is always writable
    assign cfg_ready = 1'b1;

    mmba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .flags    (flags),
        .cmd      (cmd)
    );

    mmba_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .region_index  (region_index),
        .region_base   (region_base),
        .region_end    (region_end),
        .start_address (start_address),
        .alloc_size    (alloc_size),
        .cfg_valid     (cfg_valid),
        .region_count  (region_count),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .end_address   (end_address),
        .status        (status),
        .cmd           (cmd),
        .flags         (flags)
    );

endmodule

// ----- rtl/core/mmba_ram.sv -----
`timescale 1ns / 1ps

module mmba_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/mmba_ctrl.sv -----
`timescale 1ns / 1ps
`include "memory_map_bump_allocator_defines.svh"

module mmba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mmba_pkg::dp_flags_t flags,
    output mmba_pkg::dp_cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_BWAIT = 8'b0000_0010,
        S_BCHK  = 8'b0000_0100,
        S_LIM   = 8'b0000_1000,
        S_FIT   = 8'b0001_0000,
        S_FWAIT = 8'b0010_0000,
        S_FLOAD = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // a new word is taken only between items
    assign in_stall = (state_reg != S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = mmba_pkg::STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    priority if (!flags.is_alloc)
                    begin
                        cmd.wr_region = 1'b1;
                        cmd.set_res   = 1'b1;
                        cmd.res_code  = mmba_pkg::STAT_STORED;
                        state_next    = S_DONE;
                    end
                    else if (flags.no_regions)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = mmba_pkg::STAT_NO_SPACE;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BWAIT;
                    end
                end
            end
            S_BWAIT:
            begin
                state_next = S_BCHK;
            end
            // backward search for the last region at or below the start
            S_BCHK:
            begin
                priority if (flags.start_below_base && flags.entry_zero)
                begin
                    cmd.take_base = 1'b1;
                    cmd.take_end  = 1'b1;
                    state_next    = S_LIM;
                end
                else if (flags.start_below_base)
                begin
                    cmd.entry_dec = 1'b1;
                    state_next    = S_BWAIT;
                end
                else
                begin
                    cmd.take_end = 1'b1;
                    state_next   = S_LIM;
                end
            end
            // limit check, start rounded up to a page
            S_LIM:
            begin
                cmd.calc_align = 1'b1;
                if (flags.beyond_limit)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = mmba_pkg::STAT_LIMIT;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_FIT;
                end
            end
            // fit check against the region end, else step forward or end with no space
            S_FIT:
            begin
                priority if (flags.fits)
                begin
                    cmd.set_res     = 1'b1;
                    cmd.res_code    = mmba_pkg::STAT_OK;
                    cmd.res_use_sum = 1'b1;
                    state_next      = S_DONE;
                end
                else if (flags.last_entry)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = mmba_pkg::STAT_NO_SPACE;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.entry_inc = 1'b1;
                    state_next    = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                state_next = S_FLOAD;
            end
            S_FLOAD:
            begin
                cmd.take_base = 1'b1;
                cmd.take_end  = 1'b1;
                state_next    = S_LIM;
            end
            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MMBA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != S_IDLE, "accepted word did not start work")
    `MMBA_ASSERT(a_dec_not_at_zero, cmd.entry_dec, !flags.entry_zero, "backward search stepped below region zero")

endmodule

// ----- rtl/core/mmba_datapath.sv -----
`timescale 1ns / 1ps
`include "memory_map_bump_allocator_defines.svh"

module mmba_datapath #(
    parameter int MAX_REGIONS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op,
    input  logic [3:0]           region_index,
    input  logic [63:0]          region_base,
    input  logic [63:0]          region_end,
    input  logic [63:0]          start_address,
    input  logic [31:0]          alloc_size,
    input  logic                 cfg_valid,
    input  logic [4:0]           region_count,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [63:0]          end_address,
    output logic [1:0]           status,
    input  mmba_pkg::dp_cmd_t    cmd,
    output mmba_pkg::dp_flags_t  flags
);

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = ((AW > 5) ? AW : 5) + 1;

    logic [4:0]                 region_count_reg, region_count_next;
    logic [CW-1:0]              count_ext;
    logic [CW-1:0]              count_m1;
    logic [AW-1:0]              entry_reg, entry_next;
    logic [63:0]                start_reg, start_next;
    logic [31:0]                size_reg, size_next;
    logic [63:0]                end_reg, end_next;
    logic [32:0]                aligned_reg, aligned_next;
    mmba_pkg::result_code_t     res_code_reg, res_code_next;
    logic [63:0]                res_end_reg, res_end_next;
    logic                       out_valid_reg, out_valid_next;
    logic [63:0]                end_address_reg, end_address_next;
    mmba_pkg::result_code_t     status_reg, status_next;
    logic                       idx_ok;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [127:0]               ram_wr_data;
    logic [127:0]               ram_rd_data;
    logic [63:0]                rd_base;
    logic [63:0]                rd_end;
    logic [64:0]                limit_sum;
    logic [32:0]                page_round;
    logic [33:0]                fit_sum;

    // region table, base and end side by side
    assign idx_ok      = (int'(region_index) < MAX_REGIONS);
    assign ram_wr_en   = cmd.wr_region && idx_ok;
    assign ram_wr_addr = AW'(region_index);
    assign ram_wr_data = {region_base, region_end};

    mmba_ram #(
        .WIDTH (128),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (entry_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_base = ram_rd_data[127:64];
    assign rd_end  = ram_rd_data[63:0];

    // region count clamped to the table depth
    assign count_ext = (CW'(region_count_reg) > CW'(MAX_REGIONS)) ?
                       CW'(MAX_REGIONS) : CW'(region_count_reg);
    assign count_m1  = count_ext - CW'(1);

    // limit check, page rounding and fit sum
    assign limit_sum  = {1'b0, start_reg} + 65'(size_reg);
    assign page_round = start_reg[32:0] + 33'(mmba_pkg::PAGE_BYTES - 1);
    assign fit_sum    = 34'(aligned_reg) + 34'(size_reg);

    // status back to the controller
    always_comb
    begin
        flags.is_alloc         = op;
        flags.no_regions       = (count_ext == '0);
        flags.start_below_base = (start_reg < rd_base);
        flags.entry_zero       = (entry_reg == '0);
        flags.beyond_limit     = (start_reg > mmba_pkg::ADDR_LIMIT) ||
                                 (limit_sum > 65'(mmba_pkg::ADDR_LIMIT));
        flags.fits             = (64'(fit_sum) < end_reg);
        flags.last_entry       = ((CW'(entry_reg) + CW'(1)) >= count_ext);
        flags.out_free         = !out_valid_reg || !out_stall;
    end

    // working registers
    always_comb
    begin
        start_next   = start_reg;
        size_next    = size_reg;
        entry_next   = entry_reg;
        end_next     = end_reg;
        aligned_next = aligned_reg;
        res_code_next = res_code_reg;
        res_end_next  = res_end_reg;

        priority if (cmd.ld_item)
        begin
            start_next = start_address;
        end
        else if (cmd.take_base)
        begin
            start_next = rd_base;
        end
        else
        begin
            start_next = start_reg;
        end

        if (cmd.ld_item)
        begin
            size_next  = alloc_size;
            entry_next = count_m1[AW-1:0];
        end
        else if (cmd.entry_dec)
        begin
            entry_next = entry_reg - AW'(1);
        end
        else if (cmd.entry_inc)
        begin
            entry_next = entry_reg + AW'(1);
        end

        if (cmd.take_end)
        begin
            end_next = rd_end;
        end

        if (cmd.calc_align)
        begin
            aligned_next = page_round & ~33'(mmba_pkg::PAGE_BYTES - 1);
        end

        if (cmd.set_res)
        begin
            res_code_next = cmd.res_code;
            res_end_next  = cmd.res_use_sum ? 64'(fit_sum) : '0;
        end
    end

    // output word register and configuration
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        end_address_next  = end_address_reg;
        status_next       = status_reg;
        region_count_next = cfg_valid ? region_count : region_count_reg;
        if (cmd.emit)
        begin
            out_valid_next   = 1'b1;
            end_address_next = res_end_reg;
            status_next      = res_code_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            region_count_reg <= '0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            region_count_reg <= region_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg       <= start_next;
        size_reg        <= size_next;
        entry_reg       <= entry_next;
        end_reg         <= end_next;
        aligned_reg     <= aligned_next;
        res_code_reg    <= res_code_next;
        res_end_reg     <= res_end_next;
        end_address_reg <= end_address_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign end_address = end_address_reg;
    assign status      = status_reg;

    `MMBA_ASSERT(a_fail_zero_end, out_valid_reg && (status_reg != mmba_pkg::STAT_OK), end_address_reg == '0, "failed or store word carries a nonzero end address")
    `MMBA_ASSERT_NEXT(a_aligned_page, cmd.calc_align, aligned_reg[mmba_pkg::PAGE_BITS-1:0] == '0, "aligned start is off a page boundary")
    `MMBA_ASSERT(a_inc_in_range, cmd.entry_inc, !flags.last_entry, "forward walk stepped past the region count")

endmodule

// ----- tb/bump_alloc_checker.sv -----
`timescale 1ns / 1ps

module bump_alloc_checker #(
    parameter int   REGIONS  = 16,
    parameter logic ALLOC_OP = 1'b1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [3:0]  region_index,
    input  logic [63:0] region_base,
    input  logic [63:0] region_end,
    input  logic [63:0] start_address,
    input  logic [31:0] alloc_size,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] end_address,
    input  logic [1:0]  status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_count,
    output int          fail_count,
    output int          pending,
    output int          n_stored,
    output int          n_ok,
    output int          n_no_space,
    output int          n_limit
);
    import mmba_pkg::*;

    typedef struct {
        logic [63:0]  end_addr;
        result_code_t code;
    } alloc_result_t;

    // shadow copy of the region map and the count register
    logic [63:0]   map_base [REGIONS];
    logic [63:0]   map_end  [REGIONS];
    logic [4:0]    map_count;
    alloc_result_t result_q [$];

    // back off to the last region at or below the start, then walk forward
    function automatic result_code_t bump_allocate(input logic [63:0] start_in,
                                                   input logic [31:0] size,
                                                   output logic [63:0] end_out);
        int unsigned  live;
        int unsigned  slot;
        logic [63:0]  cur;
        logic [64:0]  reach;
        logic [63:0]  aligned;
        logic         walking;
        result_code_t code;

        end_out = '0;
        code    = STAT_NO_SPACE;
        live    = (map_count > REGIONS) ? REGIONS : int'(map_count);
        if (live != 0)
        begin
            slot = live - 1;
            cur  = start_in;
            while (cur < map_base[slot])
            begin
                if (slot == 0)
                    cur = map_base[0];
                else
                    slot--;
            end
            walking = 1'b1;
            while (walking)
            begin
                // sum formed one bit wider so it cannot wrap
                reach = {1'b0, cur} + {33'd0, size};
                if (reach > {1'b0, ADDR_LIMIT})
                begin
                    code    = STAT_LIMIT;
                    walking = 1'b0;
                end
                else
                begin
                    aligned = (cur + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);
                    if (aligned + 64'(size) < map_end[slot])
                    begin
                        code    = STAT_OK;
                        end_out = aligned + 64'(size);
                        walking = 1'b0;
                    end
                    else if (slot + 1 >= live)
                        walking = 1'b0;
                    else
                    begin
                        slot++;
                        cur = map_base[slot];
                    end
                end
            end
        end
        return code;
    endfunction

    // retire results first, then take config and new words
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            map_count = '0;
            result_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: expected none, got end_address %h status %0d",
                             $time, end_address, status);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (end_address !== want.end_addr)
                    begin
                        $display("%0t ERROR end_address: expected %h, got %h",
                                 $time, want.end_addr, end_address);
                        fail_count++;
                    end
                    if (status !== want.code)
                    begin
                        $display("%0t ERROR status: expected %s, got %0d",
                                 $time, want.code.name(), status);
                        fail_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
                map_count = cfg_count;

            if (in_valid && !in_stall)
            begin
                if (op != ALLOC_OP)
                begin
                    map_base[region_index] = region_base;
                    map_end[region_index]  = region_end;
                    want.end_addr = '0;
                    want.code     = STAT_STORED;
                    n_stored++;
                end
                else
                begin
                    want.code = bump_allocate(start_address, alloc_size, want.end_addr);
                    case (want.code)
                        STAT_OK:       n_ok++;
                        STAT_LIMIT:    n_limit++;
                        default:       n_no_space++;
                    endcase
                end
                result_q.push_back(want);
            end

            pending <= result_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mmba_pkg::*;

    localparam int   MAX_REGIONS  = 16;
    localparam logic OP_REGION    = 1'b0;
    localparam logic OP_ALLOC     = 1'b1;
    localparam int   LAYOUT_LOW   = 0;
    localparam int   LAYOUT_HIGH  = 1;
    localparam int   LAYOUT_NOISE = 2;
    localparam int   PHASES       = 8;
    localparam int   PHASE_WORDS  = 230;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   TAIL_CYCLES  = 120;
    localparam int   CYCLE_LIMIT  = 1_000_000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        op            = OP_REGION;
    logic [3:0]  region_index  = '0;
    logic [63:0] region_base   = '0;
    logic [63:0] region_end    = '0;
    logic [63:0] start_address = '0;
    logic [31:0] alloc_size    = '0;
    logic        out_stall     = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic [4:0]  cfg_count     = '0;
    logic        in_stall;
    logic        out_valid;
    logic [63:0] end_address;
    logic [1:0]  status;
    logic        cfg_ready;

    int          in_gap_pct    = 0;
    int          out_stall_pct = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          cycles        = 0;
    logic [63:0] lay_base [MAX_REGIONS];
    logic [63:0] lay_end  [MAX_REGIONS];

    int          fail_count;
    int          pending;
    int          n_stored;
    int          n_ok;
    int          n_no_space;
    int          n_limit;

    memory_map_bump_allocator #(
        .MAX_REGIONS(MAX_REGIONS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .region_index (region_index),
        .region_base  (region_base),
        .region_end   (region_end),
        .start_address(start_address),
        .alloc_size   (alloc_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .end_address  (end_address),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .region_count (cfg_count)
    );

    bump_alloc_checker #(
        .REGIONS (MAX_REGIONS),
        .ALLOC_OP(OP_ALLOC)
    ) alloc_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .region_index (region_index),
        .region_base  (region_base),
        .region_end   (region_end),
        .start_address(start_address),
        .alloc_size   (alloc_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .end_address  (end_address),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_count    (cfg_count),
        .fail_count   (fail_count),
        .pending      (pending),
        .n_stored     (n_stored),
        .n_ok         (n_ok),
        .n_no_space   (n_no_space),
        .n_limit      (n_limit)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // offer one word, with optional idle cycles ahead of it
    task automatic send_word(input logic        op_v,
                             input logic [3:0]  idx,
                             input logic [63:0] base_v,
                             input logic [63:0] end_v,
                             input logic [63:0] start_v,
                             input logic [31:0] size_v);
        while ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= op_v;
        region_index  <= idx;
        region_base   <= base_v;
        region_end    <= end_v;
        start_address <= start_v;
        alloc_size    <= size_v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // count register is only written while the block is idle
    task automatic set_region_count(input logic [4:0] count_v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_count <= count_v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [63:0] addr;
        logic [63:0] span;
        logic [63:0] start;
        logic [31:0] size;
        logic [4:0]  count_sel;
        int          kind;
        int          slot;
        int          live;
        int          phase;
        int          n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no regions yet: all-zero and all-one fields
        send_word(OP_ALLOC, 4'h0, '0, '0, '0, '0);
        send_word(OP_ALLOC, 4'hF, '1, '1, '1, '1);

        // ascending map with unaligned bases, last slot straddling 4 GiB
        for (slot = 0; slot < MAX_REGIONS; slot++)
        begin
            if (slot == MAX_REGIONS - 1)
            begin
                lay_base[slot] = 64'hFFFF_0000;
                lay_end[slot]  = 64'h1_0000_0800;
            end
            else
            begin
                lay_base[slot] = 64'(slot) * 64'h1000_0000 + 64'h800;
                lay_end[slot]  = lay_base[slot] + 64'h0800_0000;
            end
            send_word(OP_REGION, 4'(slot), lay_base[slot], lay_end[slot],
                      {$urandom, $urandom}, $urandom);
        end
        set_region_count(5'd16);

        // start below the first base falls back to region 0
        send_word(OP_ALLOC, 4'h3, {$urandom, $urandom}, {$urandom, $urandom},
                  64'h0, 32'h10);
        // start in a gap, first fit is the next region
        send_word(OP_ALLOC, 4'h5, {$urandom, $urandom}, {$urandom, $urandom},
                  64'h2000_0000, 32'h0);
        // sum past 4 GiB
        send_word(OP_ALLOC, 4'h7, {$urandom, $urandom}, {$urandom, $urandom},
                  64'h5000_0000, 32'hFFFF_FFFF);
        // limit passes before alignment, aligned end lands above 4 GiB
        send_word(OP_ALLOC, 4'h9, {$urandom, $urandom}, {$urandom, $urandom},
                  64'hFFFF_FFFF, 32'h1);
        // start itself above the limit
        send_word(OP_ALLOC, 4'hB, {$urandom, $urandom}, {$urandom, $urandom},
                  64'h1_0000_0001, 32'h0);
        // last region too short after alignment
        send_word(OP_ALLOC, 4'hD, {$urandom, $urandom}, {$urandom, $urandom},
                  64'hFFFF_F001, 32'hFFF);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // idle pattern of this phase
            case (phase % 4)
                0:
                begin
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_gap_pct    = 45;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_gap_pct    = 0;
                    out_stall_pct = 45;
                end
                default:
                begin
                    in_gap_pct    = 38;
                    out_stall_pct = 38;
                end
            endcase

            // fresh map: sorted low, sorted across 4 GiB, or random
            kind = phase % 3;
            if (kind == LAYOUT_HIGH)
                addr = 64'hFE00_0000 + 64'($urandom_range(32'h0010_0000));
            else
                addr = 64'($urandom_range(32'h0010_0000));
            for (slot = 0; slot < MAX_REGIONS; slot++)
            begin
                if (kind == LAYOUT_NOISE)
                begin
                    if ($urandom_range(1) == 1)
                        lay_base[slot] = {$urandom, $urandom};
                    else
                        lay_base[slot] = {31'd0, 1'($urandom_range(1)), $urandom};
                    lay_end[slot] = lay_base[slot] + 64'($urandom);
                end
                else
                begin
                    if (kind == LAYOUT_HIGH)
                        span = 64'($urandom_range(32'h100, 32'h40_0000));
                    else
                        span = 64'($urandom_range(32'h100, 32'h200_0000));
                    if ($urandom_range(9) == 0)
                        span = 64'($urandom_range(32'h20));
                    lay_base[slot] = addr + 64'($urandom_range(32'h4_0000));
                    lay_end[slot]  = lay_base[slot] + span;
                    addr           = lay_end[slot];
                end
                send_word(OP_REGION, 4'(slot), lay_base[slot], lay_end[slot],
                          {$urandom, $urandom}, $urandom);
            end

            // count settings, extremes included
            case (phase)
                0:       count_sel = 5'd16;
                1:       count_sel = 5'd31;
                2:       count_sel = 5'd1;
                3:       count_sel = 5'd16;
                4:       count_sel = 5'd0;
                5:       count_sel = 5'($urandom_range(2, 15));
                6:       count_sel = 5'd17;
                default: count_sel = 5'($urandom_range(31));
            endcase
            live = (count_sel > MAX_REGIONS) ? MAX_REGIONS : int'(count_sel);
            set_region_count(count_sel);

            for (n = 0; n < PHASE_WORDS; n++)
            begin
                // back-pressure: long receiver hold-off, then a full drain
                if (phase == 2 && n == 40)
                    hold_req = 1'b1;
                if (phase == 5 && n == 120)
                    wait_drained();

                slot = $urandom_range(live > 0 ? live - 1 : MAX_REGIONS - 1);
                span = lay_end[slot] - lay_base[slot];
                if ($urandom_range(4) == 0)
                begin
                    // rewrite one slot: mostly a nudge, sometimes garbage
                    if ($urandom_range(3) == 0)
                    begin
                        lay_base[slot] = {$urandom, $urandom};
                        lay_end[slot]  = {$urandom, $urandom};
                    end
                    else
                    begin
                        lay_base[slot] += 64'($urandom_range(32'h800));
                        lay_end[slot]  -= 64'($urandom_range(32'h800));
                    end
                    send_word(OP_REGION, 4'(slot), lay_base[slot], lay_end[slot],
                              {$urandom, $urandom}, $urandom);
                end
                else
                begin
                    // start address around the chosen region
                    case ($urandom_range(9))
                        0, 1, 2: start = lay_base[slot] + 64'($urandom_range(
                                     span > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : span[31:0]));
                        3:       start = lay_base[slot];
                        4:       start = lay_base[0] - 64'($urandom_range(32'h1000));
                        5:       start = lay_end[slot] - 64'($urandom_range(1, 32'h1000));
                        6:       start = {$urandom, $urandom};
                        7:       start = ADDR_LIMIT - 64'($urandom_range(32'h2000))
                                         + 64'($urandom_range(1));
                        8:       start = {32'd0, $urandom};
                        default: start = lay_end[slot] + 64'($urandom_range(32'h1_0000));
                    endcase
                    // size: small, zero, huge, or near the region length
                    case ($urandom_range(9))
                        0, 1, 2, 3: size = $urandom_range(32'h1_0000);
                        4:          size = '0;
                        5:          size = $urandom;
                        6:          size = 32'hFFFF_FFFF - $urandom_range(32'h10);
                        7, 8:       size = span[31:0] - $urandom_range(32'h3000);
                        default:    size = $urandom_range(32'h100_0000);
                    endcase
                    send_word(OP_ALLOC, 4'($urandom), {$urandom, $urandom},
                              {$urandom, $urandom}, start, size);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d region stores and %0d allocations over %0d count settings",
                 n_stored, n_ok + n_no_space + n_limit, PHASES + 1);
        $display("Allocation outcomes: %0d placed, %0d out of space, %0d past 4 GiB",
                 n_ok, n_no_space, n_limit);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mmba_pkg.sv
rtl/core/mmba_ram.sv
rtl/core/mmba_ctrl.sv
rtl/core/mmba_datapath.sv
rtl/core/memory_map_bump_allocator.sv
tb/bump_alloc_checker.sv
tb/tb_top.sv
